[rtl/core/mas_pkg.sv]
// Package for the misaligned access splitter: result kinds, item classes,
// split pattern codes and RV32 decode constants. No dependencies.
package mas_pkg;

  typedef enum logic [2:0] {
    KIND_READ_BYTE  = 3'd0,
    KIND_READ_HALF  = 3'd1,
    KIND_WRITE_BYTE = 3'd2,
    KIND_WRITE_HALF = 3'd3,
    KIND_DONE       = 3'd4,
    KIND_UNHANDLED  = 3'd5
  } kind_t;

  // Class of a captured item, settled at the input register.
  typedef enum logic [1:0] {
    ITEM_UNHANDLED = 2'd0,
    ITEM_LOAD      = 2'd1,
    ITEM_STORE     = 2'd2,
    ITEM_RETURN    = 2'd3
  } item_t;

  // Split patterns, shared by loads and stores.
  localparam logic [1:0] PAT_HALF_ODD = 2'd0;
  localparam logic [1:0] PAT_WORD_ODD = 2'd1;
  localparam logic [1:0] PAT_WORD_TWO = 2'd2;

  localparam logic       CMD_ACCESS = 1'b0;
  localparam logic       CMD_RETURN = 1'b1;

  localparam logic [31:0] CAUSE_LOAD_MISALIGNED  = 32'd4;
  localparam logic [31:0] CAUSE_STORE_MISALIGNED = 32'd6;
  localparam logic [6:0]  OPC_LOAD  = 7'h03;
  localparam logic [6:0]  OPC_STORE = 7'h23;
  localparam logic [2:0]  WIDTH_HALF = 3'd1;
  localparam logic [2:0]  WIDTH_WORD = 3'd2;

endpackage

[rtl/core/misaligned_access_splitter.sv]
// Top level of the misaligned access splitter: input register, result
// sequencer, load tracking state and output register. Uses mas_pkg.
//
// A trapped RV32 LH/LW or SH/SW at a misaligned address is split into byte
// and halfword bus operations. Send a new trap as command 0; send each read
// return as command 1. The effective address is formed as an item is taken,
// and the item then sits in an input register while its results leave one
// per cycle unless stalled through the output register: a load or an
// unhandled access gives one result, a read return one result (or none when
// no load is pending), a store three or four. The sequencer that walks the
// results of the held item sets the rate: one item per cycle for
// single-result items unless stalled; a split store holds the input until
// its final result. The next item is taken in the cycle the held one issues
// its final result, so a waiting result never blocks the input side for more
// than the output register can absorb. A new trap while a load is pending
// drops that load.
module misaligned_access_splitter
  import mas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_cause,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_store_value,
  input  logic [15:0] in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_address,
  output logic [15:0] out_write_data,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_dest_value,
  output logic        out_dest_write,
  output logic        out_last
);

  // ---------------------------------------------------------------------
  // Input decode: classify the item and form the effective address.
  // ---------------------------------------------------------------------
  logic        in_accept;
  logic [6:0]  dec_opc;
  logic [2:0]  dec_width;
  logic [31:0] dec_imm;
  logic [31:0] dec_addr;
  logic        dec_is_load;
  logic        dec_is_store;
  item_t       dec_item;
  logic [1:0]  dec_pat;

  assign dec_opc   = in_instruction[6:0];
  assign dec_width = in_instruction[14:12];

  always_comb begin
    dec_is_load  = (in_cause == CAUSE_LOAD_MISALIGNED) && (dec_opc == OPC_LOAD);
    dec_is_store = (in_cause == CAUSE_STORE_MISALIGNED) && (dec_opc == OPC_STORE);
    // I-type immediate for loads, S-type for stores; both sign extended
    if (dec_is_store) begin
      dec_imm = {{20{in_instruction[31]}}, in_instruction[31:25], in_instruction[11:7]};
    end else begin
      dec_imm = {{20{in_instruction[31]}}, in_instruction[31:20]};
    end
    dec_addr = in_base_value + dec_imm;

    dec_pat  = PAT_HALF_ODD;
    dec_item = ITEM_UNHANDLED;
    if (dec_width == WIDTH_HALF && dec_addr[0]) begin
      dec_pat = PAT_HALF_ODD;
    end else if (dec_width == WIDTH_WORD && dec_addr[0]) begin
      dec_pat = PAT_WORD_ODD;
    end else begin
      dec_pat = PAT_WORD_TWO;
    end
    if (in_command == CMD_RETURN) begin
      dec_item = ITEM_RETURN;
    end else if ((dec_is_load || dec_is_store) &&
                 ((dec_width == WIDTH_HALF && dec_addr[0]) ||
                  (dec_width == WIDTH_WORD && dec_addr[1:0] != 2'b00))) begin
      dec_item = dec_is_load ? ITEM_LOAD : ITEM_STORE;
    end
  end

  // ---------------------------------------------------------------------
  // Input register: holds one item while its results are issued.
  // ---------------------------------------------------------------------
  logic        s1_valid_r;
  item_t       s1_item_r;
  logic [1:0]  s1_pat_r;
  logic [31:0] s1_addr_r;
  logic [31:0] s1_sval_r;
  logic [4:0]  s1_dest_r;
  logic [15:0] s1_rdata_r;

  // Pending load state
  logic        load_pending_r;
  logic [1:0]  load_pattern_r;
  logic [1:0]  load_step_r;
  logic [31:0] load_address_r;
  logic [4:0]  load_dest_r;
  logic [31:0] gathered_r;

  // Result sequencer and output register
  logic [1:0]  seq_r;
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_address_r;
  logic [15:0] out_write_data_r;
  logic [4:0]  out_dest_reg_r;
  logic [31:0] out_dest_value_r;
  logic        out_dest_write_r;
  logic        out_last_r;

  logic        out_room;
  logic        no_result;
  logic        res_last;
  logic        emit;
  logic        item_fire;

  // ---------------------------------------------------------------------
  // Read return merge, worked from the pending load state.
  // ---------------------------------------------------------------------
  logic [31:0] merged;
  logic [1:0]  step_nxt;
  logic [1:0]  nsteps;
  logic        load_done;
  logic [31:0] final_value;

  always_comb begin
    unique case (load_pattern_r)
      PAT_WORD_ODD: begin
        nsteps = 2'd3;
        if (load_step_r == 2'd0) begin
          merged = {24'd0, s1_rdata_r[7:0]};
        end else if (load_step_r == 2'd1) begin
          merged = gathered_r | {8'd0, s1_rdata_r, 8'd0};
        end else begin
          merged = gathered_r | {s1_rdata_r[7:0], 24'd0};
        end
      end
      PAT_WORD_TWO: begin
        nsteps = 2'd2;
        if (load_step_r == 2'd0) begin
          merged = {16'd0, s1_rdata_r};
        end else begin
          merged = gathered_r | {s1_rdata_r, 16'd0};
        end
      end
      default: begin
        // half at an odd address; the unused pattern code behaves the same
        nsteps = 2'd2;
        if (load_step_r == 2'd0) begin
          merged = {24'd0, s1_rdata_r[7:0]};
        end else begin
          merged = gathered_r | {16'd0, s1_rdata_r[7:0], 8'd0};
        end
      end
    endcase
    step_nxt  = load_step_r + 2'd1;
    load_done = (step_nxt >= nsteps);
    if (load_pattern_r == PAT_WORD_ODD || load_pattern_r == PAT_WORD_TWO) begin
      final_value = merged;
    end else begin
      final_value = {{16{merged[15]}}, merged[15:0]};
    end
  end

  // ---------------------------------------------------------------------
  // Result selection for the held item at sequence index seq_r.
  // ---------------------------------------------------------------------
  kind_t       res_kind;
  logic [31:0] res_base;
  logic [1:0]  res_off;
  logic        res_bus;
  logic [31:0] res_addr;
  logic [15:0] res_wdata;
  logic [4:0]  res_dreg;
  logic [31:0] res_dval;
  logic        res_dwr;
  logic [1:0]  res_count_m1;

  always_comb begin
    res_kind     = KIND_UNHANDLED;
    res_base     = s1_addr_r;
    res_off      = 2'd0;
    res_bus      = 1'b0;
    res_wdata    = 16'd0;
    res_dreg     = 5'd0;
    res_dval     = 32'd0;
    res_dwr      = 1'b0;
    res_count_m1 = 2'd0;
    no_result    = 1'b0;

    unique case (s1_item_r)
      ITEM_LOAD: begin
        // first read sits at the effective address itself
        res_bus  = 1'b1;
        res_kind = (s1_pat_r == PAT_WORD_TWO) ? KIND_READ_HALF : KIND_READ_BYTE;
      end
      ITEM_STORE: begin
        res_count_m1 = (s1_pat_r == PAT_WORD_ODD) ? 2'd3 : 2'd2;
        if (seq_r == res_count_m1) begin
          res_kind = KIND_DONE;
        end else begin
          res_bus = 1'b1;
          unique case (s1_pat_r)
            PAT_WORD_ODD: begin
              if (seq_r == 2'd0) begin
                res_kind  = KIND_WRITE_BYTE;
                res_wdata = {8'd0, s1_sval_r[7:0]};
              end else if (seq_r == 2'd1) begin
                res_kind  = KIND_WRITE_HALF;
                res_off   = 2'd1;
                res_wdata = s1_sval_r[23:8];
              end else begin
                res_kind  = KIND_WRITE_BYTE;
                res_off   = 2'd3;
                res_wdata = {8'd0, s1_sval_r[31:24]};
              end
            end
            PAT_WORD_TWO: begin
              res_kind = KIND_WRITE_HALF;
              if (seq_r == 2'd0) begin
                res_wdata = s1_sval_r[15:0];
              end else begin
                res_off   = 2'd2;
                res_wdata = s1_sval_r[31:16];
              end
            end
            default: begin
              res_kind = KIND_WRITE_BYTE;
              if (seq_r == 2'd0) begin
                res_wdata = {8'd0, s1_sval_r[7:0]};
              end else begin
                res_off   = 2'd1;
                res_wdata = {8'd0, s1_sval_r[15:8]};
              end
            end
          endcase
        end
      end
      ITEM_RETURN: begin
        no_result = !load_pending_r;
        res_base  = load_address_r;
        if (!load_done) begin
          // issue the next read of the pending load
          res_bus = 1'b1;
          unique case (load_pattern_r)
            PAT_WORD_ODD: begin
              if (step_nxt == 2'd1) begin
                res_kind = KIND_READ_HALF;
                res_off  = 2'd1;
              end else if (step_nxt == 2'd0) begin
                res_kind = KIND_READ_BYTE;
              end else begin
                res_kind = KIND_READ_BYTE;
                res_off  = 2'd3;
              end
            end
            PAT_WORD_TWO: begin
              res_kind = KIND_READ_HALF;
              res_off  = (step_nxt != 2'd0) ? 2'd2 : 2'd0;
            end
            default: begin
              res_kind = KIND_READ_BYTE;
              res_off  = (step_nxt != 2'd0) ? 2'd1 : 2'd0;
            end
          endcase
        end else begin
          res_kind = KIND_DONE;
          if (load_dest_r != 5'd0) begin
            res_dreg = load_dest_r;
            res_dval = final_value;
            res_dwr  = 1'b1;
          end
        end
      end
      default: begin
        res_kind = KIND_UNHANDLED;
      end
    endcase

    res_addr = res_bus ? (res_base + {30'd0, res_off}) : 32'd0;
  end

  assign res_last  = (seq_r == res_count_m1);
  assign out_room  = !out_valid_r || !out_stall;
  assign emit      = s1_valid_r && !no_result && out_room;
  assign item_fire = s1_valid_r && (no_result || (out_room && res_last));
  assign in_stall  = s1_valid_r && !item_fire;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      seq_r          <= 2'd0;
      out_valid_r    <= 1'b0;
      load_pending_r <= 1'b0;
      load_pattern_r <= PAT_HALF_ODD;
      load_step_r    <= 2'd0;
    end else begin
      // input register: take a new item as the held one leaves
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (item_fire) begin
        s1_valid_r <= 1'b0;
      end

      // sequencer: advance per issued result, rewind at the final one
      if (emit) begin
        seq_r <= res_last ? 2'd0 : seq_r + 2'd1;
      end

      // output register: drop a taken result, hold a stalled one
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // pending load state changes only as an item leaves
      if (item_fire) begin
        if (s1_item_r == ITEM_RETURN) begin
          if (load_pending_r) begin
            load_pending_r <= !load_done;
            load_step_r    <= load_done ? 2'd0 : step_nxt;
          end
        end else begin
          // a new trap drops any pending load
          load_pending_r <= (s1_item_r == ITEM_LOAD);
          load_step_r    <= 2'd0;
          if (s1_item_r == ITEM_LOAD) begin
            load_pattern_r <= s1_pat_r;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r  <= dec_item;
      s1_pat_r   <= dec_pat;
      s1_addr_r  <= dec_addr;
      s1_sval_r  <= in_store_value;
      s1_dest_r  <= in_instruction[11:7];
      s1_rdata_r <= in_read_data;
    end
    if (item_fire) begin
      if (s1_item_r == ITEM_RETURN) begin
        if (load_pending_r) begin
          gathered_r <= merged;
        end
      end else if (s1_item_r == ITEM_LOAD) begin
        load_address_r <= s1_addr_r;
        load_dest_r    <= s1_dest_r;
        gathered_r     <= 32'd0;
      end
    end
    if (emit) begin
      out_kind_r       <= res_kind;
      out_address_r    <= res_addr;
      out_write_data_r <= res_wdata;
      out_dest_reg_r   <= res_dreg;
      out_dest_value_r <= res_dval;
      out_dest_write_r <= res_dwr;
      out_last_r       <= res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = 3'(out_kind_r);
  assign out_address    = out_address_r;
  assign out_write_data = out_write_data_r;
  assign out_dest_reg   = out_dest_reg_r;
  assign out_dest_value = out_dest_value_r;
  assign out_dest_write = out_dest_write_r;
  assign out_last       = out_last_r;

endmodule
